// ===== hdl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// Types and constants shared by the timing statistics accumulator.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam logic [30:0] PERIOD_RESET   = 31'd5000000;
  localparam logic [31:0] ALL_ONES       = 32'hffff_ffff;
  localparam int          PROD_W         = 33;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] report_count;
    logic [31:0] report_sum;
    logic [31:0] report_square_sum;
  } out_item_t;

  // Interval with its square product (pre-scaled above the low band), handed to the accumulator stage
  typedef struct packed {
    logic [31:0]       d;
    logic [31:0]       end_time;
    logic [PROD_W-1:0] prod;
    logic              low_band;
    logic              over;
  } sq_item_t;

endpackage

// ===== hdl/tsa_square.sv =====
// ----------------------------------------------------------------------------
// tsa_square
// Input register, interval length and square product stage.
// ----------------------------------------------------------------------------
module tsa_square
  import tsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     sq_valid,
  output sq_item_t sq_item,
  input  logic     sq_take
);

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] end_time;
  } len_item_t;

  logic        s1_valid_r;
  len_item_t   s1_r;
  logic        s2_valid_r;
  sq_item_t    s2_r;
  sq_item_t    s2_nxt;

  logic        s1_move;
  logic        s1_free;
  logic        s2_free;
  logic        low_band;
  logic [12:0] ceil_d;
  logic [15:0] op_a;
  logic [19:0] op_b;
  logic [35:0] prod_full;

  assign s2_free  = !s2_valid_r || sq_take;
  assign s1_move  = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_move;
  assign in_stall = !s1_free;

  assign low_band  = (s1_r.d[31:16] == 16'd0);
  assign ceil_d    = {1'b0, s1_r.d[19:8]} + {12'd0, |s1_r.d[7:0]};
  assign op_a      = low_band ? s1_r.d[15:0] : {3'd0, ceil_d};
  assign op_b      = low_band ? {4'd0, s1_r.d[15:0]} : s1_r.d[19:0];
  assign prod_full = op_a * op_b;

  always_comb begin
    s2_nxt.d        = s1_r.d;
    s2_nxt.end_time = s1_r.end_time;
    s2_nxt.prod     = prod_full[PROD_W-1:0];
    s2_nxt.low_band = low_band;
    s2_nxt.over     = |s1_r.d[31:20];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_r.d        <= in_item.end_time - in_item.start_time;
      s1_r.end_time <= in_item.end_time;
    end
    if (s1_move) begin
      s2_r <= s2_nxt;
    end
  end

  assign sq_valid = s2_valid_r;
  assign sq_item  = s2_r;

endmodule

// ===== hdl/tsa_accum.sv =====
// ----------------------------------------------------------------------------
// tsa_accum
// Accumulators, report period compare and report output register.
// ----------------------------------------------------------------------------
module tsa_accum
  import tsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data,
  input  logic        sq_valid,
  input  sq_item_t    sq_item,
  output logic        sq_take,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  logic [30:0] period_r;
  logic [31:0] count_r;
  logic [31:0] sum_r;
  logic [31:0] square_r;
  logic [31:0] last_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [31:0] count_nxt;
  logic [31:0] sum_nxt;
  logic [31:0] square_nxt;
  logic [32:0] term;
  logic [33:0] total;
  logic [31:0] deadline;
  logic [31:0] delta;
  logic        report;
  logic        out_free;

  assign term = sq_item.low_band
              ? {9'd0, sq_item.prod[31:8] + {23'd0, |sq_item.prod[7:0]}}
              : sq_item.prod;
  assign total      = {2'b00, square_r} + {1'b0, term};
  assign square_nxt = (sq_item.over || (total[33:32] != 2'b00)) ? ALL_ONES : total[31:0];
  assign count_nxt  = count_r + 32'd1;
  assign sum_nxt    = sum_r + sq_item.d;

  assign deadline = last_r + {1'b0, period_r};
  assign delta    = sq_item.end_time - deadline;
  assign report   = !delta[31];

  assign out_free = !out_valid_r || !out_stall;
  assign sq_take  = sq_valid && (!report || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      square_r    <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (out_free) begin
        out_valid_r <= sq_valid && report;
      end
      if (sq_take) begin
        if (report) begin
          count_r  <= '0;
          sum_r    <= '0;
          square_r <= '0;
          last_r   <= sq_item.end_time;
        end else begin
          count_r  <= count_nxt;
          sum_r    <= sum_nxt;
          square_r <= square_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_take && report) begin
      out_r.report_count      <= count_nxt;
      out_r.report_sum        <= sum_nxt;
      out_r.report_square_sum <= square_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/timing_stats_accumulator.sv =====
// A report passes registers s1_r, s2_r and out_r before it leaves on out_item.
// Throughput: one transaction per cycle while in_stall is low.
// A waiting report only holds back transactions that raise a further report.
// Reset (rst_n low, synchronous): pipeline emptied, accumulators and last report
// time cleared, report period set to 5000000 ticks.
// ----------------------------------------------------------------------------
// timing_stats_accumulator
// Interval count, sum and scaled sum of squares with periodic reports.
// ----------------------------------------------------------------------------
module timing_stats_accumulator
  import tsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  logic     sq_valid;
  logic     sq_take;
  sq_item_t sq_item;

  tsa_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .sq_valid (sq_valid),
    .sq_item  (sq_item),
    .sq_take  (sq_take)
  );

  tsa_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sq_valid    (sq_valid),
    .sq_item     (sq_item),
    .sq_take     (sq_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ===== test/tb_timing_stats_accumulator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timing_stats_accumulator
// Self-checking bench for the interval statistics block. Intervals are sent
// with a running time cursor so that report periods elapse regularly, mixed
// with fully random transactions. A predictor works out each report when its
// transaction is accepted, and returned reports are compared field by field.
// Both channels idle at random. The bench also holds the receiver off for a
// long stretch and drains between report period settings.
// ----------------------------------------------------------------------------
module tb_timing_stats_accumulator;
  import tsa_pkg::*;

  localparam int          CYCLE_LIMIT   = 400_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 400;
  localparam logic [31:0] SQ_SMALL_MAX  = 32'h0000_ffff;
  localparam logic [31:0] SQ_MID_MAX    = 32'h000f_ffff;
  localparam logic [31:0] SQ_ROUND      = 32'd255;
  localparam logic [30:0] PERIOD_MAX    = 31'h7fff_ffff;

  class stats_scoreboard;
    logic [30:0] period;
    logic [31:0] count;
    logic [31:0] len_sum;
    logic [31:0] sq_sum;
    logic [31:0] last_report;
    out_item_t   reports_q[$];
    int          errors;
    int          items_seen;
    int          reports_seen;

    function new();
      period       = PERIOD_RESET;
      count        = '0;
      len_sum      = '0;
      sq_sum       = '0;
      last_report  = '0;
      errors       = 0;
      items_seen   = 0;
      reports_seen = 0;
    endfunction

    function int pending();
      return reports_q.size();
    endfunction

    function void set_period(logic [30:0] p);
      period = p;
    endfunction

    function logic [31:0] add_scaled_square(logic [31:0] acc, logic [31:0] d);
      logic [63:0] term;
      logic [63:0] total;
      if (d > SQ_MID_MAX) return ALL_ONES;
      if (d <= SQ_SMALL_MAX) begin
        term = ({32'd0, d} * {32'd0, d} + {32'd0, SQ_ROUND}) >> 8;
      end else begin
        term = (({32'd0, d} + {32'd0, SQ_ROUND}) >> 8) * {32'd0, d};
      end
      total = {32'd0, acc} + term;
      return (total > {32'd0, ALL_ONES}) ? ALL_ONES : total[31:0];
    endfunction

    // Accumulate first, then test the end time against the report deadline
    function void note_item(in_item_t txn);
      logic [31:0] d;
      logic [31:0] lag;
      out_item_t   rpt;
      d       = txn.end_time - txn.start_time;
      count   = count + 32'd1;
      len_sum = len_sum + d;
      sq_sum  = add_scaled_square(sq_sum, d);
      items_seen++;
      lag = txn.end_time - (last_report + {1'b0, period});
      if (!lag[31]) begin
        rpt.report_count      = count;
        rpt.report_sum        = len_sum;
        rpt.report_square_sum = sq_sum;
        reports_q.push_back(rpt);
        last_report = txn.end_time;
        count       = '0;
        len_sum     = '0;
        sq_sum      = '0;
      end
    endfunction

    function void field_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
    endfunction

    function void check_report(out_item_t got);
      out_item_t exp_r;
      if (reports_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, got %h %h %h", $time,
                 got.report_count, got.report_sum, got.report_square_sum);
        return;
      end
      exp_r = reports_q.pop_front();
      reports_seen++;
      if (got.report_count !== exp_r.report_count)
        field_mismatch("report_count", exp_r.report_count, got.report_count);
      if (got.report_sum !== exp_r.report_sum)
        field_mismatch("report_sum", exp_r.report_sum, got.report_sum);
      if (got.report_square_sum !== exp_r.report_square_sum)
        field_mismatch("report_square_sum", exp_r.report_square_sum,
                       got.report_square_sum);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [30:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  stats_scoreboard sb = new();

  int          cycle_count   = 0;
  int          phase_count   = 0;
  bit          sender_quiet  = 1'b0;
  bit          sink_quiet    = 1'b0;
  bit          hold_request  = 1'b0;
  logic [30:0] cur_period    = PERIOD_RESET;
  logic [31:0] gen_last      = '0;
  logic [31:0] now_time      = '0;

  timing_stats_accumulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d reports outstanding",
               cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_report(out_item);
      if (in_valid && !in_stall) sb.note_item(in_item);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_length();
    logic [31:0] edges[10];
    int          r;
    edges = '{32'h0, 32'h1, 32'hff, 32'h100, 32'hffff, 32'h1_0000,
              32'hf_ffff, 32'h10_0000, 32'h7fff_ffff, 32'hffff_ffff};
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, SQ_SMALL_MAX);
    if (r < 60) return $urandom_range(SQ_SMALL_MAX + 1, SQ_MID_MAX);
    if (r < 70) return edges[$urandom_range(0, 9)];
    if (r < 80) return $urandom;
    return $urandom_range(0, 255);
  endfunction

  // Mirror of the report deadline, only to keep the time cursor useful
  function automatic void track_report(logic [31:0] e);
    logic [31:0] lag;
    lag = e - (gen_last + {1'b0, cur_period});
    if (!lag[31]) gen_last = e;
  endfunction

  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        hold = sink_quiet ? 0 : pick_gap();
        out_stall <= (hold != 0);
        repeat ((hold == 0) ? 1 : hold) @(posedge clk);
      end
    end
  end

  task automatic send_interval(logic [31:0] s, logic [31:0] e);
    in_item_t txn;
    int       gap;
    txn.start_time = s;
    txn.end_time   = e;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= txn;
    do @(posedge clk); while (in_stall);
    track_report(e);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [30:0] p);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_period(p);
    cur_period = p;
    phase_count++;
  endtask

  task automatic run_phase(logic [30:0] p, int n, bit quiet, bit hold);
    logic [31:0] span;
    logic [31:0] d;
    logic [31:0] e;
    write_period(p);
    sender_quiet = quiet;
    sink_quiet   = quiet;
    hold_request = hold;
    now_time     = gen_last;
    span         = ({1'b0, p} / 32'd3) + 32'd2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        e = $urandom;
        send_interval($urandom, e);
        now_time = gen_last;
      end else begin
        now_time = now_time + $urandom_range(0, span);
        d = pick_length();
        send_interval(now_time - d, now_time);
      end
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset period, square bands at their edges, saturation and time wrap
    send_interval(32'h0, 32'h0);
    send_interval(32'h0, 32'h1);
    send_interval(32'd1000 - 32'hff, 32'd1000);
    send_interval(32'd1000 - 32'h100, 32'd1000);
    send_interval(32'd1000 - 32'hffff, 32'd1000);
    send_interval(32'd1000 - 32'h1_0000, 32'd1000);
    send_interval(32'd1000 - 32'hf_ffff, 32'd1000);
    send_interval(32'h0, 32'd4_999_999);
    send_interval(32'd4_999_999, 32'd5_000_000);
    send_interval(32'd5_000_001 - 32'h10_0000, 32'd5_000_001);
    send_interval(32'h1, 32'h0);
    send_interval(32'd10_000_000 - 32'hf_ffff, 32'd10_000_000);
    send_interval(32'hffff_ffff, 32'hffff_ffff);
    send_interval(32'h7fff_0000, 32'h8000_0000);
    // two full mid-band squares overflow the sum of squares
    send_interval(32'h8000_0001 - 32'hf_ffff, 32'h8000_0001);
    send_interval(32'h8000_0001 - 32'hf_ffff, 32'h8000_0001);
    send_interval(32'h8000_0000 + 32'd5_000_000 - 32'hffff,
                  32'h8000_0000 + 32'd5_000_000);
    // zero period reports whenever the end time is not behind
    write_period(31'd0);
    send_interval(gen_last, gen_last);
    send_interval(gen_last - 32'd5, gen_last - 32'd1);
    send_interval(32'h0, gen_last);
    write_period(PERIOD_MAX);
    send_interval(gen_last, gen_last + 32'h7fff_fffe);
    send_interval(gen_last, gen_last + 32'h7fff_ffff);
    write_period(31'd1);
    send_interval(gen_last, gen_last);
    send_interval(gen_last, gen_last + 32'd1);

    run_phase(PERIOD_RESET, 100, 1'b0, 1'b0);
    run_phase(31'd1, 110, 1'b0, 1'b0);
    run_phase(31'd0, 100, 1'b1, 1'b0);
    run_phase(PERIOD_MAX, 110, 1'b0, 1'b0);
    run_phase(31'($urandom_range(2, 5000)), 110, 1'b0, 1'b0);
    run_phase(31'($urandom), 100, 1'b0, 1'b0);
    // receiver held off while the zero period makes each cursor-driven transaction raise a report
    run_phase(31'd0, 40, 1'b1, 1'b1);
    run_phase(31'd1000, 80, 1'b0, 1'b0);

    settle();
    $display("Covered %0d transactions and %0d reports across %0d period settings,",
             sb.items_seen, sb.reports_seen, phase_count);
    $display("zero, one and the largest period included, with one %0d-cycle receiver hold.",
             LONG_HOLD);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== timing_stats_accumulator.f =====
hdl/tsa_pkg.sv
hdl/tsa_square.sv
hdl/tsa_accum.sv
hdl/timing_stats_accumulator.sv
test/tb_timing_stats_accumulator.sv
